### design/assert_macros.svh
// Assertion helpers for the port demux design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/pdsq_pkg.sv
package pdsq_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [2:0] MODE_REGISTER   = 3'd0;
    localparam logic [2:0] MODE_UNREGISTER = 3'd1;
    localparam logic [2:0] MODE_DELIVER    = 3'd2;
    localparam logic [2:0] MODE_QUEUE_OUT  = 3'd3;
    localparam logic [2:0] MODE_TAKE_IN    = 3'd4;
    localparam logic [2:0] MODE_TAKE_OUT   = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TABLE_FULL = 3'd1;
    localparam logic [2:0] ST_NO_MATCH   = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;
    localparam logic [2:0] ST_UNUSED     = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  protocol;
        logic [15:0] port;
        logic [15:0] socket_id;
        logic [3:0]  slot;
        logic [15:0] packet_handle;
    } pdsq_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_out;
        logic [15:0] handle_out;
        logic [15:0] socket_out;
    } pdsq_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture input beat, look up table
        logic exec;     // commit the decided operation
        logic finish;   // capture read data into the result
    } pdsq_cmd_t;

endpackage

### design/pdsq_datapath.sv
module pdsq_datapath
    import pdsq_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  pdsq_cmd_t cmd,
    input  pdsq_in_t  in_beat,
    output pdsq_out_t result
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QW1 = QW + 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = SW + QW;

    logic [7:0]    prot_reg [SLOTS];
    logic [15:0]   port_reg [SLOTS];
    logic [15:0]   sock_reg [SLOTS];
    logic [QW-1:0] ihead_reg [SLOTS];
    logic [CW-1:0] icnt_reg [SLOTS];
    logic [QW-1:0] ehead_reg [SLOTS];
    logic [CW-1:0] ecnt_reg [SLOTS];

    logic [15:0] ing_mem [2**AW];
    logic [15:0] egr_mem [2**AW];

    pdsq_in_t    beat_reg;
    logic        hit_reg, free_ok_reg;
    logic [SW-1:0] hit_idx_reg, free_idx_reg;

    // Parallel tag compare and free-slot priority pick on the live input.
    logic        hit_c, free_c;
    logic [SW-1:0] hit_i, free_i;
    always_comb begin
        hit_c = 1'b0;
        free_c = 1'b0;
        hit_i = '0;
        free_i = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (prot_reg[i] != 8'd0 && prot_reg[i] == in_beat.protocol &&
                port_reg[i] == in_beat.port) begin
                hit_c = 1'b1;
                hit_i = SW'(i);
            end
            if (prot_reg[i] == 8'd0) begin
                free_c = 1'b1;
                free_i = SW'(i);
            end
        end
    end

    // Decode the operation from the captured beat.
    logic          s_in_range;
    logic [SW-1:0] s_idx;
    logic          s_used;
    logic [SW-1:0] q_slot;
    logic          do_push_i, do_push_e, do_pop_i, do_pop_e, do_reg, do_unreg;
    logic [2:0]    st_c;
    logic [3:0]    so_c;
    logic [15:0]   sk_c;
    logic [QW-1:0] wpos;
    logic [QW:0]   wsum;

    always_comb begin
        s_in_range = {28'd0, beat_reg.slot} < SLOTS;
        s_idx = SW'(beat_reg.slot);
        s_used = s_in_range && prot_reg[s_idx] != 8'd0;
        q_slot = s_idx;
        do_push_i = 1'b0; do_push_e = 1'b0; do_pop_i = 1'b0; do_pop_e = 1'b0;
        do_reg = 1'b0; do_unreg = 1'b0;
        st_c = ST_NO_MATCH; so_c = '0; sk_c = '0;
        case (beat_reg.mode)
            MODE_REGISTER: begin
                if (beat_reg.protocol == 8'd0) begin
                    st_c = ST_NO_MATCH;
                end else if (hit_reg) begin
                    st_c = ST_OK; so_c = 4'(hit_idx_reg); sk_c = sock_reg[hit_idx_reg];
                end else if (!free_ok_reg) begin
                    st_c = ST_TABLE_FULL;
                end else begin
                    do_reg = 1'b1;
                    st_c = ST_OK; so_c = 4'(free_idx_reg); sk_c = beat_reg.socket_id;
                end
            end
            MODE_UNREGISTER: begin
                if (!s_in_range) begin
                    st_c = ST_UNUSED; so_c = beat_reg.slot;
                end else begin
                    do_unreg = 1'b1;
                    st_c = ST_OK; so_c = beat_reg.slot; sk_c = sock_reg[s_idx];
                end
            end
            MODE_DELIVER: begin
                if (hit_reg && beat_reg.protocol != 8'd0) begin
                    q_slot = hit_idx_reg;
                    so_c = 4'(hit_idx_reg); sk_c = sock_reg[hit_idx_reg];
                    if (32'(icnt_reg[hit_idx_reg]) >= QUEUE_DEPTH) begin
                        st_c = ST_FULL;
                    end else begin
                        st_c = ST_OK; do_push_i = 1'b1;
                    end
                end
            end
            MODE_QUEUE_OUT, MODE_TAKE_IN, MODE_TAKE_OUT: begin
                so_c = beat_reg.slot;
                if (!s_used) begin
                    st_c = ST_UNUSED;
                end else begin
                    sk_c = sock_reg[s_idx];
                    st_c = ST_OK;
                    if (beat_reg.mode == MODE_QUEUE_OUT) begin
                        if (32'(ecnt_reg[s_idx]) >= QUEUE_DEPTH) st_c = ST_FULL;
                        else do_push_e = 1'b1;
                    end else if (beat_reg.mode == MODE_TAKE_IN) begin
                        if (icnt_reg[s_idx] == '0) st_c = ST_EMPTY;
                        else do_pop_i = 1'b1;
                    end else begin
                        if (ecnt_reg[s_idx] == '0) st_c = ST_EMPTY;
                        else do_pop_e = 1'b1;
                    end
                end
            end
            default: begin
                st_c = ST_NO_MATCH;
            end
        endcase
        // Tail position: head plus count, wrapped once past the queue depth.
        if (do_push_i) wsum = {1'b0, ihead_reg[q_slot]} + QW1'(icnt_reg[q_slot]);
        else           wsum = {1'b0, ehead_reg[q_slot]} + QW1'(ecnt_reg[q_slot]);
        if (32'(wsum) >= QUEUE_DEPTH) wsum = wsum - QW1'(QUEUE_DEPTH);
        wpos = wsum[QW-1:0];
    end

    logic [2:0]  st_reg;
    logic [3:0]  so_reg;
    logic [15:0] sk_reg;
    logic        pop_reg;
    logic [15:0] rd_i_reg, rd_e_reg;
    logic        pop_e_reg;

    function automatic logic [QW-1:0] incq(input logic [QW-1:0] v);
        return (32'(v) + 1 >= QUEUE_DEPTH) ? '0 : QW'(32'(v) + 1);
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            beat_reg <= in_beat;
            hit_reg <= hit_c;
            hit_idx_reg <= hit_i;
            free_ok_reg <= free_c;
            free_idx_reg <= free_i;
        end
        if (cmd.exec) begin
            st_reg <= st_c; so_reg <= so_c; sk_reg <= sk_c;
            pop_reg <= do_pop_i | do_pop_e;
            pop_e_reg <= do_pop_e;
            rd_i_reg <= ing_mem[{q_slot, ihead_reg[q_slot]}];
            rd_e_reg <= egr_mem[{q_slot, ehead_reg[q_slot]}];
            if (do_push_i) ing_mem[{q_slot, wpos}] <= beat_reg.packet_handle;
            if (do_push_e) egr_mem[{q_slot, wpos}] <= beat_reg.packet_handle;
        end
        if (cmd.finish) begin
            result.status <= st_reg;
            result.slot_out <= so_reg;
            result.socket_out <= sk_reg;
            result.handle_out <= pop_reg ? (pop_e_reg ? rd_e_reg : rd_i_reg) : 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                prot_reg[i] <= '0; port_reg[i] <= '0; sock_reg[i] <= '0;
                ihead_reg[i] <= '0; icnt_reg[i] <= '0;
                ehead_reg[i] <= '0; ecnt_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            if (do_reg) begin
                prot_reg[free_idx_reg] <= beat_reg.protocol;
                port_reg[free_idx_reg] <= beat_reg.port;
                sock_reg[free_idx_reg] <= beat_reg.socket_id;
                ihead_reg[free_idx_reg] <= '0;
                icnt_reg[free_idx_reg] <= '0;
            end
            if (do_unreg) begin
                prot_reg[s_idx] <= '0; port_reg[s_idx] <= '0; sock_reg[s_idx] <= '0;
                ihead_reg[s_idx] <= '0; icnt_reg[s_idx] <= '0;
                ehead_reg[s_idx] <= '0; ecnt_reg[s_idx] <= '0;
            end
            if (do_push_i) icnt_reg[q_slot] <= icnt_reg[q_slot] + 1'b1;
            if (do_push_e) ecnt_reg[q_slot] <= ecnt_reg[q_slot] + 1'b1;
            if (do_pop_i) begin
                icnt_reg[q_slot] <= icnt_reg[q_slot] - 1'b1;
                ihead_reg[q_slot] <= incq(ihead_reg[q_slot]);
            end
            if (do_pop_e) begin
                ecnt_reg[q_slot] <= ecnt_reg[q_slot] - 1'b1;
                ehead_reg[q_slot] <= incq(ehead_reg[q_slot]);
            end
        end
    end

endmodule

### design/pdsq_ctrl.sv
`include "assert_macros.svh"
module pdsq_ctrl
    import pdsq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output pdsq_cmd_t cmd
);
    typedef enum logic [1:0] {IDLE, LOOK, EXEC, DONE} state_t;
    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    // Accept a new beat only in IDLE and when no result is waiting, or it leaves now.
    assign s_ready = (state_reg == IDLE) && (!mv_reg || m_ready);
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next = mv_reg;
        cmd = '0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = LOOK;
                end
            end
            LOOK: begin
                cmd.exec = 1'b1;
                state_next = EXEC;
            end
            EXEC: begin
                if (!mv_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    mv_next = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
    end

    `ASSERT_CLK(a_one_exec, aclk, aresetn, cmd.load |=> cmd.exec, "exec must follow load")
    `ASSERT_CLK(a_no_accept_busy, aclk, aresetn, (state_reg != IDLE) |-> !s_ready, "accept while busy")
    `ASSERT_CLK(a_finish_valid, aclk, aresetn, cmd.finish |=> m_valid, "result not shown")
endmodule

### design/port_demux_service_queues.sv
// The accepted beat is captured with its tag compare in IDLE, the queue update commits in LOOK,
// and EXEC captures the result and raises m_valid; no new item is taken until EXEC is left.
// A result waiting on m_ready holds off the next input beat (s_ready stays low).
// Reset (aresetn low, synchronous) frees all slots and empties every queue;
// queue memory contents are not cleared.
module port_demux_service_queues
    import pdsq_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pdsq_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output pdsq_out_t m_data
);
    pdsq_cmd_t cmd;

    // Sequence load, update and result capture.
    pdsq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd)
    );

    // Hold the service table, queue pointers and queue memories.
    pdsq_datapath #(.SLOTS(SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .in_beat(s_data), .result(m_data)
    );
endmodule
